@@ rtl/mqlb_pkg.sv @@
`default_nettype none

package mqlb_pkg;

    localparam int NUM_ENTRIES = 16;
    localparam int NUM_QUEUES  = 4;

    // entry index, link code (one extra code for null), queue index
    localparam int ENTRY_W = $clog2(NUM_ENTRIES);
    localparam int LINK_W  = $clog2(NUM_ENTRIES + 1);
    localparam int QIDX_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NUM_ENTRIES);

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic               opcode;
        logic [1:0]         queue_id;
        logic signed [31:0] data_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] data_out;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic               rd_en;
        logic [ENTRY_W-1:0] rd_addr;
        logic               wr_en;
        logic [ENTRY_W-1:0] wr_addr;
        logic [LINK_W-1:0]  wr_data;
    } t_link_req;

endpackage

`default_nettype wire

@@ rtl/mqlb_ram.sv @@
`default_nettype none

module mqlb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/mqlb_link_mem.sv @@
`default_nettype none

module mqlb_link_mem
    import mqlb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_link_req         i_req,
    output logic      [LINK_W-1:0] o_rd_data
);

    logic [LINK_W-1:0]      r_mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] r_written;

    // entry never written reads as its reset link: next entry, last one null
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_req.wr_en) begin
            r_written[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            if (r_written[i_req.rd_addr]) begin
                o_rd_data <= r_mem[i_req.rd_addr];
            end else begin
                o_rd_data <= LINK_W'(i_req.rd_addr) + LINK_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/multi_queue_linked_buffer.sv @@
`default_nettype none

// Several FIFO queues sharing one pool of NUM_ENTRIES data words. A link
// memory chains each queue from head to tail and chains the free entries into
// a free list; per-queue head/tail pointers and the free-list head live in
// registers. Each input transfer is an enqueue (opcode 0) or dequeue
// (opcode 1) on queue_id, and yields exactly one result transfer: status OK
// with the dequeued word, status FULL when an enqueue finds no free entry or
// names no queue, status EMPTY when a dequeue finds the queue empty or names
// no queue (data_out is zero unless a dequeue succeeds). Each item passes
// through a transfer cycle, in which the link and data memories are read at
// the free-list head (enqueue) or the queue head (dequeue), and an update
// cycle, in which the links are rewritten and the result register loaded.
// The next input is taken the cycle after the update, so a new item is not
// accepted until the previous one has been committed; the update cycle waits
// while the result register holds a transfer the consumer has not yet taken.
// Link memory reset is handled by per-entry written flags, so there is no
// clearing pass after reset.
module multi_queue_linked_buffer
    import mqlb_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;

    // item held for the update cycle, and the entry pointer read for it
    t_in_item          r_item;
    logic [LINK_W-1:0] r_slot;

    logic [LINK_W-1:0] r_free_head, n_free_head;
    logic [LINK_W-1:0] r_head [NUM_QUEUES];
    logic [LINK_W-1:0] r_tail [NUM_QUEUES];
    logic [LINK_W-1:0] n_head, n_tail;

    logic      r_out_valid;
    t_out_item r_out, n_out;

    logic              w_accept, w_commit;
    logic [QIDX_W-1:0] w_in_qidx, w_cur_qidx;
    logic [LINK_W-1:0] w_rd_ptr;
    logic [LINK_W-1:0] w_head_cur, w_tail_cur;
    logic              w_q_ok, w_slot_ok, w_head_ok, w_tail_ok;
    logic              w_upd;      // state changes on this commit
    logic              w_head_we, w_tail_we;
    logic              w_data_we;

    t_link_req         w_link_req;
    logic [LINK_W-1:0] w_link_rd;
    logic [31:0]       w_data_rd;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_commit   = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign w_in_qidx  = QIDX_W'(i_in_data.queue_id);
    assign w_cur_qidx = QIDX_W'(r_item.queue_id);

    // dequeue reads at the queue head, enqueue at the free-list head
    assign w_rd_ptr = (i_in_data.opcode == OP_DEQ) ? r_head[w_in_qidx] : r_free_head;

    assign w_head_cur = r_head[w_cur_qidx];
    assign w_tail_cur = r_tail[w_cur_qidx];
    assign w_q_ok     = int'(r_item.queue_id) < NUM_QUEUES;
    assign w_slot_ok  = int'(r_slot) < NUM_ENTRIES;
    assign w_head_ok  = int'(w_head_cur) < NUM_ENTRIES;
    assign w_tail_ok  = int'(w_tail_cur) < NUM_ENTRIES;
    assign w_upd      = w_commit && w_q_ok && w_slot_ok;

    always_comb begin
        w_link_req.rd_en   = w_accept;
        w_link_req.rd_addr = w_rd_ptr[ENTRY_W-1:0];
        w_link_req.wr_en   = 1'b0;
        w_link_req.wr_addr = r_slot[ENTRY_W-1:0];
        w_link_req.wr_data = r_free_head;

        w_data_we   = 1'b0;
        w_head_we   = 1'b0;
        w_tail_we   = 1'b0;
        n_head      = w_head_cur;
        n_tail      = w_tail_cur;
        n_free_head = r_free_head;
        n_out       = '0;

        if (r_item.opcode == OP_ENQ) begin
            n_out.status = ST_FULL;
            if (w_q_ok && w_slot_ok) begin
                n_out.status = ST_OK;
                n_free_head  = w_link_rd;
                w_data_we    = w_upd;
                w_tail_we    = w_upd;
                n_tail       = r_slot;
                if (!w_head_ok) begin
                    // first entry of an empty queue
                    w_head_we = w_upd;
                    n_head    = r_slot;
                end else if (w_tail_ok) begin
                    w_link_req.wr_en   = w_upd;
                    w_link_req.wr_addr = w_tail_cur[ENTRY_W-1:0];
                    w_link_req.wr_data = r_slot;
                end
            end
        end else begin
            n_out.status = ST_EMPTY;
            if (w_q_ok && w_slot_ok) begin
                n_out.status   = ST_OK;
                n_out.data_out = w_data_rd;
                // head == tail means the last entry leaves; the tail's link is
                // never written null, so this stands in for reading it
                w_head_we      = w_upd;
                n_head         = (r_slot == w_tail_cur) ? LINK_NULL : w_link_rd;
                w_link_req.wr_en   = w_upd;
                w_link_req.wr_data = r_free_head;
                n_free_head    = r_slot;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_free_head <= '0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= LINK_NULL;
                r_tail[i] <= LINK_NULL;
            end
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_upd) begin
                r_free_head <= n_free_head;
            end
            if (w_head_we) begin
                r_head[w_cur_qidx] <= n_head;
            end
            if (w_tail_we) begin
                r_tail[w_cur_qidx] <= n_tail;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
            r_slot <= w_rd_ptr;
        end
        if (w_commit) begin
            r_out <= n_out;
        end
    end

    mqlb_link_mem u_link_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_link_req),
        .o_rd_data (w_link_rd)
    );

    mqlb_ram #(
        .WIDTH (32),
        .DEPTH (NUM_ENTRIES)
    ) u_data_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_data_we),
        .i_wr_addr (r_slot[ENTRY_W-1:0]),
        .i_wr_data (r_item.data_in),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rd_ptr[ENTRY_W-1:0]),
        .o_rd_data (w_data_rd)
    );

endmodule

`default_nettype wire
